// ===== sv/implicit_array_bst_table_macros.svh =====
// Assertion macros shared by the checker.
`ifndef IMPLICIT_ARRAY_BST_TABLE_MACROS_SVH
`define IMPLICIT_ARRAY_BST_TABLE_MACROS_SVH
`define IABT_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IABT_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== sv/iabt_pkg.sv =====
package iabt_pkg;
   localparam int KeyWidth   = 32;
   localparam int TreeLevels = 10;
   localparam int SlotCount  = (1 << TreeLevels) - 1;
   localparam int IdxWidth   = TreeLevels + 1;
   localparam int CntWidth   = 10;

   typedef logic [KeyWidth-1:0] key_type;
   typedef logic [IdxWidth-1:0] idx_type;

   localparam logic [2:0] MODE_INSERT = 3'd0;
   localparam logic [2:0] MODE_REMOVE = 3'd1;
   localparam logic [2:0] MODE_SEARCH = 3'd2;
   localparam logic [2:0] MODE_MIN    = 3'd3;
   localparam logic [2:0] MODE_MAX    = 3'd4;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_MISS  = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   function automatic logic key_less(input key_type a, input key_type b, input logic sgn);
      key_type x;
      key_type y;
      x = a;
      y = b;
      if (sgn) begin
         x[KeyWidth-1] = ~x[KeyWidth-1];
         y[KeyWidth-1] = ~y[KeyWidth-1];
      end
      return x < y;
   endfunction
endpackage

// ===== sv/iabt_ram.sv =====
module iabt_ram #(
   parameter int Width = 32,
   parameter int Depth = 1023
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/implicit_array_bst_table.sv =====
// Channel | Ports                                            | Direction
// req     | req_valid req_stall req_mode req_key             | in
// rsp     | rsp_valid rsp_stall rsp_status rsp_found ...     | out
// csr     | csr_valid csr_ready csr_data                     | in
// After reset a clearing pass marks all 1023 slots empty, and requests stall.
// Slots are probed one at a time, after the request is accepted and before the result is shown.
// Insert, search, min and max probe at most 11 slots.
// Remove also probes each replacement path, slot by slot.
// The result waits in an output register; a stall holds it and keeps the block busy.
module implicit_array_bst_table (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_mode,
   input  logic [31:0]           req_key,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic                  rsp_found,
   output logic [31:0]           rsp_key_out,
   output logic [9:0]            rsp_entry_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data
);
   import iabt_pkg::*;

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_WALK = 3'd2;
   localparam logic [2:0] S_SUCC = 3'd3;
   localparam logic [2:0] S_PRED = 3'd4;
   localparam logic [2:0] S_EXT  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   localparam int AW = $clog2(SlotCount);
   localparam int SW = KeyWidth + 1;

   logic [2:0]          state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                sgn_ff, sgn_in;
   logic [2:0]          mode_ff, mode_in;
   key_type             key_ff, key_in;
   idx_type             idx_ff, idx_in;
   idx_type             del_ff, del_in;
   idx_type             cand_ff, cand_in;
   key_type             ckey_ff, ckey_in;
   logic                right_ff, right_in;
   logic [1:0]          status_ff, status_in;
   logic                found_ff, found_in;
   logic [31:0]         kout_ff, kout_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [SW-1:0]       wr_data, rd_data;
   key_type             slot_key;
   logic                slot_live;
   logic                less;

   // Each slot holds its occupied bit above the key.
   iabt_ram #(.Width(SW), .Depth(SlotCount)) u_slots (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   function automatic idx_type child(input idx_type i, input logic go_right);
      return idx_type'({i[IdxWidth-2:0], 1'b0} + {1'b0, go_right, ~go_right});
   endfunction

   // The read address follows the next slot, so its contents arrive with it.
   assign rd_addr   = idx_in[AW-1:0];
   assign slot_key  = rd_data[KeyWidth-1:0];
   assign slot_live = (idx_ff < idx_type'(SlotCount)) && rd_data[KeyWidth];
   assign less      = key_less(key_ff, slot_key, sgn_ff);

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_status = status_ff;
   assign rsp_found = found_ff;
   assign rsp_key_out = kout_ff;
   assign rsp_entry_count = cnt_ff;

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; cnt_in = cnt_ff;
      sgn_in = (csr_valid) ? csr_data : sgn_ff;
      mode_in = mode_ff; key_in = key_ff; idx_in = idx_ff; del_in = del_ff;
      cand_in = cand_ff; ckey_in = ckey_ff;
      right_in = right_ff; status_in = status_ff; found_in = found_ff;
      kout_in = kout_ff;
      wr_en = 1'b0; wr_addr = del_ff[AW-1:0]; wr_data = {1'b1, ckey_ff};
      unique case (state_ff)
         S_CLR: begin
            wr_en = 1'b1; wr_addr = clr_ff; wr_data = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(SlotCount - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               mode_in = req_mode; key_in = req_key; idx_in = '0;
               status_in = ST_DONE; found_in = 1'b0; kout_in = '0;
               right_in = (req_mode == MODE_MAX);
               if (req_mode <= MODE_MAX) begin
                  state_in = S_WALK;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_WALK: begin
            if (mode_ff == MODE_MIN || mode_ff == MODE_MAX) begin
               if (slot_live) begin
                  cand_in = idx_ff; ckey_in = slot_key;
                  idx_in = child(idx_ff, right_ff); state_in = S_EXT;
               end else begin
                  status_in = ST_EMPTY; state_in = S_OUT;
               end
            end else if (!slot_live) begin
               if (mode_ff != MODE_INSERT) begin
                  status_in = ST_MISS;
               end else if (idx_ff >= idx_type'(SlotCount)) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = {1'b1, key_ff};
                  cnt_in = cnt_ff + 1'b1;
               end
               state_in = S_OUT;
            end else if (slot_key == key_ff) begin
               found_in = 1'b1;
               if (mode_ff == MODE_INSERT) begin
                  status_in = ST_MISS; state_in = S_OUT;
               end else if (mode_ff == MODE_SEARCH) begin
                  state_in = S_OUT;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
                  del_in = idx_ff; idx_in = child(idx_ff, 1'b1); state_in = S_SUCC;
               end
            end else begin
               idx_in = child(idx_ff, !less);
            end
         end
         S_SUCC: begin
            if (slot_live) begin
               cand_in = idx_ff; ckey_in = slot_key; right_in = 1'b0;
               idx_in = child(idx_ff, 1'b0); state_in = S_EXT;
            end else begin
               idx_in = child(del_ff, 1'b0); state_in = S_PRED;
            end
         end
         S_PRED: begin
            if (slot_live) begin
               cand_in = idx_ff; ckey_in = slot_key; right_in = 1'b1;
               idx_in = child(idx_ff, 1'b1); state_in = S_EXT;
            end else begin
               wr_en = 1'b1; wr_data = '0; state_in = S_OUT;
            end
         end
         S_EXT: begin
            if (slot_live) begin
               cand_in = idx_ff; ckey_in = slot_key;
               idx_in = child(idx_ff, right_ff);
            end else if (mode_ff == MODE_REMOVE) begin
               wr_en = 1'b1;
               del_in = cand_ff; idx_in = child(cand_ff, 1'b1); state_in = S_SUCC;
            end else begin
               kout_in = ckey_ff; state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR; clr_ff <= '0; cnt_ff <= '0; sgn_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; cnt_ff <= cnt_in; sgn_ff <= sgn_in;
      end
      mode_ff <= mode_in; key_ff <= key_in; idx_ff <= idx_in; del_ff <= del_in;
      cand_ff <= cand_in; ckey_ff <= ckey_in;
      right_ff <= right_in; status_ff <= status_in; found_ff <= found_in;
      kout_ff <= kout_in;
   end
endmodule

// ===== sv/iabt_checker.sv =====
`include "implicit_array_bst_table_macros.svh"
module iabt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic        rsp_found,
   input logic [31:0] rsp_key_out,
   input logic [9:0]  rsp_entry_count
);
   import iabt_pkg::*;

   `IABT_ASSERT_IMPL(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_out), "Stalled item changed.")
   `IABT_ASSERT_IMPL(a_busy, clock, reset, rsp_valid |-> req_stall,
      "Item accepted while a result waits.")
   `IABT_ASSERT_IMPL(a_found, clock, reset,
      rsp_valid && rsp_found |-> rsp_status != ST_FULL && rsp_status != ST_EMPTY,
      "Found with a wrong status.")
   `IABT_ASSERT_NORST(a_reset, clock, reset |=> !rsp_valid && rsp_entry_count == 10'd0,
      "Reset left state.")
endmodule

bind implicit_array_bst_table iabt_checker u_iabt_checker (.*);
